/* rtl/fdcc_pkg.sv */
// package for the double-precision compare unit
// holds payload structs and field constants; no dependencies
package fdcc_pkg;

	localparam int unsigned CodeW = 4;
	localparam int unsigned WordW = 64;
	localparam int unsigned ExpMsb = 62;
	localparam int unsigned ExpLsb = 52;
	localparam int unsigned FracMsb = 51;

	// condition code bit positions
	localparam int unsigned CodeUnord = 0;
	localparam int unsigned CodeEq = 1;
	localparam int unsigned CodeLt = 2;
	localparam int unsigned CodeSignal = 3;

	typedef struct packed {
		logic [CodeW-1:0] op;
		logic [WordW-1:0] first_value;
		logic [WordW-1:0] second_value;
		logic coprocessor_enabled;
	} cmp_req_t;

	typedef struct packed {
		logic condition_write;
		logic condition_bit;
		logic invalid_operation;
		logic unusable_fault;
	} cmp_rsp_t;

endpackage

/* rtl/fdcc_req_if.sv */
// request channel interface: valid/ready handshake with compare payload
// depends on fdcc_pkg
interface fdcc_req_if;
	logic valid;
	logic ready;
	fdcc_pkg::cmp_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/fdcc_rsp_if.sv */
// result channel interface: valid/ready handshake with condition payload
// depends on fdcc_pkg
interface fdcc_rsp_if;
	logic valid;
	logic ready;
	fdcc_pkg::cmp_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/fpu_double_compare_condition.sv */
// top level of the double-precision compare unit
// depends on fdcc_pkg, fdcc_req_if, fdcc_rsp_if, fdcc_eval
//
// One compare transaction is accepted per cycle while intake is not stalled. A
// transaction is captured in an input register, evaluated by 63-bit magnitude
// compares plus NaN and zero detection, and moves on into the result register.
// The result register frees as it is taken, so a stalled output stops intake
// only while both registers are full.
module fpu_double_compare_condition (
	input logic clk,
	input logic arst_n,
	fdcc_req_if.sink in_ch,
	fdcc_rsp_if.source out_ch
);
	import fdcc_pkg::*;

	logic vld_s1, vld_s2;
	cmp_req_t req_s1;
	cmp_rsp_t rsp_c, rsp_s2;
	logic adv_s2, adv_s1;

	assign adv_s2 = !vld_s2 || out_ch.ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_ch.ready = adv_s1;
	assign out_ch.valid = vld_s2;
	assign out_ch.data = rsp_s2;

	fdcc_eval u_eval (.req(req_s1), .rsp(rsp_c));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_ch.valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) req_s1 <= in_ch.data;
		if (adv_s2 && vld_s1) rsp_s2 <= rsp_c;
	end
endmodule

/* rtl/fdcc_eval.sv */
// combinational compare of two binary64 patterns against a condition code
// depends on fdcc_pkg
module fdcc_eval (
	input  fdcc_pkg::cmp_req_t req,
	output fdcc_pkg::cmp_rsp_t rsp
);
	import fdcc_pkg::*;

	logic nan_a, nan_b, unord, zeros, eq, lt, mag_lt, mag_gt;
	logic sa, sb;
	logic [WordW-2:0] ma, mb;

	// operand classification
	always_comb begin
		ma = req.first_value[WordW-2:0];
		mb = req.second_value[WordW-2:0];
		sa = req.first_value[WordW-1];
		sb = req.second_value[WordW-1];
		nan_a = (&req.first_value[ExpMsb:ExpLsb]) && (|req.first_value[FracMsb:0]);
		nan_b = (&req.second_value[ExpMsb:ExpLsb]) && (|req.second_value[FracMsb:0]);
		unord = nan_a | nan_b;
		zeros = (ma == '0) && (mb == '0);
		mag_lt = ma < mb;
		mag_gt = ma > mb;
	end

	// sign-magnitude ordering and condition
	always_comb begin
		eq = !unord && (zeros || (req.first_value == req.second_value));
		if (zeros) begin
			lt = 1'b0;
		end else if (sa != sb) begin
			lt = sa;
		end else if (!sa) begin
			lt = mag_lt;
		end else begin
			lt = mag_gt;
		end
		lt = lt && !unord;
		rsp.condition_write = req.coprocessor_enabled;
		rsp.unusable_fault = !req.coprocessor_enabled;
		rsp.condition_bit = req.coprocessor_enabled &&
			((unord && req.op[CodeUnord]) || (eq && req.op[CodeEq]) ||
			 (lt && req.op[CodeLt]));
		rsp.invalid_operation = req.coprocessor_enabled && unord && req.op[CodeSignal];
	end
endmodule

/* rtl/fdcc_checker.sv */
// port-level checker for the compare unit, bound to the top level
// depends on fdcc_pkg
module fdcc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input fdcc_pkg::cmp_rsp_t out_data
);
	// result is either a write or a fault, never both
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.condition_write != out_data.unusable_fault))
		else $error("write and fault not exclusive");

	// faulted result carries no condition or invalid flag
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.unusable_fault) |->
		(!out_data.condition_bit && !out_data.invalid_operation))
		else $error("fault result has flags");

	// input is ready whenever the output is not stalled
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("intake stalled without output stall");

	// accepted transaction passes the input register and becomes a result when unstalled
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (!out_valid || out_ready)) |=> ##1 out_valid)
		else $error("result missing");
endmodule

bind fpu_double_compare_condition fdcc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_data(out_ch.data)
);
